// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the checker files.
// PFA_ASSERT checks only outside reset; PFA_ASSERT_ALWAYS checks at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("field advance check failed");

`define PFA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("field advance reset check failed");

`endif

// ----- hw/rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Widths, codes, request structs and fixed-point helpers of the field advance.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PIDT_W    = 20;
  localparam int FIELD_W   = 32;
  // pidt (made signed) times a 32-bit current
  localparam int MUL_W     = PIDT_W + 1 + FIELD_W;
  // rounded current term, room for the doubled Ex product
  localparam int SCL_W     = MUL_W + 1 - FRAC_BITS;
  localparam int DIFF_W    = ((SCL_W > FIELD_W) ? SCL_W : FIELD_W) + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ACT_LEFT  = 2'd0;
  localparam logic [1:0] ACT_CELL  = 2'd1;
  localparam logic [1:0] ACT_RIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PIDT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LASER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LASER = 2'd2;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [SCL_W-1:0]   scl_t;

  localparam field_t FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam field_t FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  localparam logic signed [MUL_W:0] RND_HALF =
    {{(MUL_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // request after the current products have been formed
  typedef struct packed {
    logic [1:0] action;
    field_t     cur_y;
    field_t     cur_z;
    field_t     wave_fp;
    field_t     wave_fm;
    field_t     wave_gp;
    field_t     wave_gm;
    field_t     field_ex;
    scl_t       s_jx2;
    scl_t       s_jy;
    scl_t       s_jz;
  } item_t;

  typedef struct packed {
    field_t fp;
    field_t fm;
    field_t gp;
    field_t gm;
    field_t ey;
    field_t ez;
    field_t by;
    field_t bz;
    field_t ex;
  } result_t;

  // round to FRAC_BITS fraction bits, half up
  function automatic scl_t scale_round(input logic signed [MUL_W:0] p);
    logic signed [MUL_W:0] sum;
    logic signed [MUL_W:0] sh;
    sum = p + RND_HALF;
    sh  = sum >>> FRAC_BITS;
    return sh[SCL_W-1:0];
  endfunction

  // pidt times a current, rounded to FRAC_BITS fraction bits
  function automatic scl_t scale_cur(input logic [PIDT_W-1:0] pidt, input field_t j);
    logic signed [MUL_W-1:0] p;
    p = $signed({1'b0, pidt}) * j;
    return scale_round({p[MUL_W-1], p});
  endfunction

  function automatic field_t sat_field(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-FIELD_W:0] hi;
    hi = d[DIFF_W-1:FIELD_W-1];
    if ((&hi) || (~|hi)) begin
      return d[FIELD_W-1:0];
    end else if (d[DIFF_W-1]) begin
      return FIELD_MIN;
    end
    return FIELD_MAX;
  endfunction

  function automatic field_t sub_scaled(input field_t a, input scl_t b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return sat_field(d);
  endfunction

  function automatic field_t add_sat(input field_t a, input field_t b);
    logic signed [FIELD_W:0] s;
    s = (FIELD_W+1)'(a) + (FIELD_W+1)'(b);
    if (s[FIELD_W] != s[FIELD_W-1]) begin
      return s[FIELD_W] ? FIELD_MIN : FIELD_MAX;
    end
    return s[FIELD_W-1:0];
  endfunction

  function automatic field_t sub_sat(input field_t a, input field_t b);
    logic signed [FIELD_W:0] s;
    s = (FIELD_W+1)'(a) - (FIELD_W+1)'(b);
    if (s[FIELD_W] != s[FIELD_W-1]) begin
      return s[FIELD_W] ? FIELD_MIN : FIELD_MAX;
    end
    return s[FIELD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/pfa_scale.sv -----
// ----------------------------------------------------------------------------
// pfa_scale
// Input register and current product stage: pidt*j terms rounded per request.
// ----------------------------------------------------------------------------
module pfa_scale import pfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [PIDT_W-1:0] pidt,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        action,
  input  field_t            cur_x,
  input  field_t            cur_y,
  input  field_t            cur_z,
  input  field_t            wave_fp,
  input  field_t            wave_fm,
  input  field_t            wave_gp,
  input  field_t            wave_gm,
  input  field_t            field_ex,
  input  logic              take,
  output logic              b_valid,
  output item_t             b_item
);

  logic       a_valid;
  logic [1:0] a_action;
  field_t     a_cur_x, a_cur_y, a_cur_z;
  field_t     a_fp, a_fm, a_gp, a_gm, a_ex;

  logic                     b_free;
  logic                     a_free;
  logic signed [PIDT_W:0]   pidt_s;
  logic signed [MUL_W-1:0]  p_x, p_y, p_z;
  item_t                    b_item_next;

  assign b_free     = !b_valid || take;
  assign a_free     = !a_valid || b_free;
  assign item_stall = !a_free;

  assign pidt_s = {1'b0, pidt};

  always_comb begin
    p_x = pidt_s * a_cur_x;
    p_y = pidt_s * a_cur_y;
    p_z = pidt_s * a_cur_z;
    b_item_next.action   = a_action;
    b_item_next.cur_y    = a_cur_y;
    b_item_next.cur_z    = a_cur_z;
    b_item_next.wave_fp  = a_fp;
    b_item_next.wave_fm  = a_fm;
    b_item_next.wave_gp  = a_gp;
    b_item_next.wave_gm  = a_gm;
    b_item_next.field_ex = a_ex;
    b_item_next.s_jx2    = scale_round({p_x, 1'b0});
    b_item_next.s_jy     = scale_round({p_y[MUL_W-1], p_y});
    b_item_next.s_jz     = scale_round({p_z[MUL_W-1], p_z});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= item_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && item_valid) begin
      a_action <= action;
      a_cur_x  <= cur_x;
      a_cur_y  <= cur_y;
      a_cur_z  <= cur_z;
      a_fp     <= wave_fp;
      a_fm     <= wave_fm;
      a_gp     <= wave_gp;
      a_gm     <= wave_gm;
      a_ex     <= field_ex;
    end
    if (b_free && a_valid) begin
      b_item <= b_item_next;
    end
  end

endmodule

// ----- hw/rtl/pfa_solve.sv -----
// ----------------------------------------------------------------------------
// pfa_solve
// Characteristic update: carry and pending cell state, result register.
// ----------------------------------------------------------------------------
module pfa_solve import pfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [PIDT_W-1:0] pidt,
  input  logic              left_is_laser,
  input  logic              right_is_laser,
  input  logic              b_valid,
  input  item_t             b_item,
  output logic              take,
  input  logic              result_stall,
  output logic              res_valid,
  output result_t           res
);

  field_t carry_fp, carry_gm, carry_jy, carry_jz;
  scl_t   carry_sjy, carry_sjz;
  field_t pend_fp, pend_gm, pend_ex, pend_jy, pend_jz;
  scl_t   pend_sjy, pend_sjz;
  logic   pend_valid;

  logic    out_free;
  logic    is_cell, is_right;
  logic    emit;
  field_t  sfm, sgp, fm_sel, gp_sel;
  result_t res_next;

  assign out_free = !res_valid || !result_stall;
  assign take     = b_valid && out_free;

  assign is_cell  = (b_item.action == ACT_CELL);
  assign is_right = (b_item.action == ACT_RIGHT);
  assign emit     = pend_valid && (is_cell || is_right);

  always_comb begin
    sfm    = sub_scaled(b_item.wave_fm, pend_sjy);
    sgp    = sub_scaled(b_item.wave_gp, pend_sjz);
    fm_sel = (is_right && right_is_laser) ? b_item.wave_fm : sfm;
    gp_sel = (is_right && right_is_laser) ? b_item.wave_gp : sgp;
    res_next.fp = pend_fp;
    res_next.fm = fm_sel;
    res_next.gp = gp_sel;
    res_next.gm = pend_gm;
    res_next.ey = add_sat(pend_fp, fm_sel);
    res_next.ez = add_sat(gp_sel, pend_gm);
    res_next.by = sub_sat(gp_sel, pend_gm);
    res_next.bz = sub_sat(pend_fp, fm_sel);
    res_next.ex = pend_ex;
  end

  // state that feeds results is cleared so the first cell matches reset
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      carry_fp   <= '0;
      carry_gm   <= '0;
      carry_jy   <= '0;
      carry_jz   <= '0;
      carry_sjy  <= '0;
      carry_sjz  <= '0;
      pend_fp    <= '0;
      pend_gm    <= '0;
      pend_ex    <= '0;
      pend_jy    <= '0;
      pend_jz    <= '0;
      pend_sjy   <= '0;
      pend_sjz   <= '0;
    end else begin
      if (out_free) begin
        res_valid <= take && emit;
      end
      if (take) begin
        case (b_item.action)
          ACT_LEFT: begin
            carry_fp   <= b_item.wave_fp;
            carry_gm   <= b_item.wave_gm;
            carry_jy   <= left_is_laser ? '0 : b_item.cur_y;
            carry_jz   <= left_is_laser ? '0 : b_item.cur_z;
            carry_sjy  <= left_is_laser ? '0 : b_item.s_jy;
            carry_sjz  <= left_is_laser ? '0 : b_item.s_jz;
            pend_valid <= 1'b0;
          end
          ACT_CELL: begin
            pend_fp    <= sub_scaled(carry_fp, carry_sjy);
            pend_gm    <= sub_scaled(carry_gm, carry_sjz);
            pend_jy    <= b_item.cur_y;
            pend_jz    <= b_item.cur_z;
            pend_sjy   <= b_item.s_jy;
            pend_sjz   <= b_item.s_jz;
            pend_ex    <= sub_scaled(b_item.field_ex, b_item.s_jx2);
            pend_valid <= 1'b1;
            carry_fp   <= b_item.wave_fp;
            carry_gm   <= b_item.wave_gm;
            carry_jy   <= b_item.cur_y;
            carry_jz   <= b_item.cur_z;
            carry_sjy  <= b_item.s_jy;
            carry_sjz  <= b_item.s_jz;
          end
          ACT_RIGHT: begin
            pend_valid <= 1'b0;
          end
          default: begin
          end
        endcase
      end else begin
        // idle: rebuild the held terms from the raw currents so that a new
        // pidt, written while the pipeline is empty, reaches them
        carry_sjy <= scale_cur(pidt, carry_jy);
        carry_sjz <= scale_cur(pidt, carry_jz);
        pend_sjy  <= scale_cur(pidt, pend_jy);
        pend_sjz  <= scale_cur(pidt, pend_jz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/pic_1d_field_advance_unit.sv -----
// Results: a cell's result enters the result register when its follower (next cell
//   or right boundary) is taken by the update stage; boundary requests give no result.
// Throughput: one request per cycle; a stalled result holds the update stage and
//   stalls input once both pipeline registers behind it are full.
// Reset (rst, synchronous, active high): pipeline empty, carries and pending cell
//   zero, pidt = 0, left_is_laser = right_is_laser = 1.
// ----------------------------------------------------------------------------
// pic_1d_field_advance_unit
// One time step of a 1D particle-in-cell field solve along characteristics.
// ----------------------------------------------------------------------------
module pic_1d_field_advance_unit import pfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIDT_W-1:0]    cfg_data,
  // request channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           action,
  input  field_t               cur_x,
  input  field_t               cur_y,
  input  field_t               cur_z,
  input  field_t               wave_fp,
  input  field_t               wave_fm,
  input  field_t               wave_gp,
  input  field_t               wave_gm,
  input  field_t               field_ex,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output field_t               new_fp,
  output field_t               new_fm,
  output field_t               new_gp,
  output field_t               new_gm,
  output field_t               new_ey,
  output field_t               new_ez,
  output field_t               new_by,
  output field_t               new_bz,
  output field_t               new_ex
);

  // configuration registers; the user must write them only while the unit is idle (not enforced here)
  logic [PIDT_W-1:0] pidt;
  logic              left_is_laser;
  logic              right_is_laser;

  // product stage to update stage
  logic    b_valid;
  item_t   b_item;
  logic    take;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pidt           <= '0;
      left_is_laser  <= 1'b1;
      right_is_laser <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIDT:        pidt           <= cfg_data;
        CFG_LEFT_LASER:  left_is_laser  <= cfg_data[0];
        CFG_RIGHT_LASER: right_is_laser <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Stage 1/2: request register, then pidt*j products rounded to Q format.
  // Only this request's own currents are scaled here, so the stage never
  // waits on solver state; the carry and pending terms store scaled values,
  // refreshed from their raw currents whenever the update stage is idle.
  pfa_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .pidt       (pidt),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .cur_z      (cur_z),
    .wave_fp    (wave_fp),
    .wave_fm    (wave_fm),
    .wave_gp    (wave_gp),
    .wave_gm    (wave_gm),
    .field_ex   (field_ex),
    .take       (take),
    .b_valid    (b_valid),
    .b_item     (b_item)
  );

  // Stage 3: subtract and saturate, update carries and the pending cell,
  // and load the result register when a pending cell completes.
  pfa_solve u_solve (
    .clk            (clk),
    .rst            (rst),
    .pidt           (pidt),
    .left_is_laser  (left_is_laser),
    .right_is_laser (right_is_laser),
    .b_valid        (b_valid),
    .b_item         (b_item),
    .take           (take),
    .result_stall   (result_stall),
    .res_valid      (result_valid),
    .res            (res)
  );

  assign new_fp = res.fp;
  assign new_fm = res.fm;
  assign new_gp = res.gp;
  assign new_gm = res.gm;
  assign new_ey = res.ey;
  assign new_ez = res.ez;
  assign new_by = res.by;
  assign new_bz = res.bz;
  assign new_ex = res.ex;

endmodule

// ----- hw/rtl/pfa_checker.sv -----
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the field advance unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfa_checker import pfa_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   item_stall,
  input logic   result_valid,
  input logic   result_stall,
  input field_t new_fp,
  input field_t new_fm,
  input field_t new_ey,
  input field_t new_bz
);

  logic opp_sign;
  assign opp_sign = new_fp[FIELD_W-1] ^ new_fm[FIELD_W-1];

  // result register empty after reset
  `PFA_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid)

  // with the result side open the pipeline always drains, so requests flow
  `PFA_ASSERT(a_no_stall_when_open, !result_stall |-> !item_stall)

  // opposite signs cannot overflow, so Ey is the plain sum
  `PFA_ASSERT(a_ey_sum, (result_valid && opp_sign) |-> (new_ey == new_fp + new_fm))

  // equal signs cannot overflow a difference, so Bz is exact
  `PFA_ASSERT(a_bz_diff, (result_valid && !opp_sign) |-> (new_bz == new_fp - new_fm))

  // a held result stays valid and keeps its Ey value
  `PFA_ASSERT(a_hold, (result_valid && result_stall) |=> (result_valid && $stable(new_ey)))

endmodule

bind pic_1d_field_advance_unit pfa_checker u_pfa_checker (.*);
